// ===== src/refcounted_timed_slot_pool_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the slot pool unit.
// Each macro checks on the rising clock edge and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_TIMED_SLOT_POOL_UNIT_MACROS_SVH
`define REFCOUNTED_TIMED_SLOT_POOL_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold on every clock edge.
`define SRP_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("slot pool assertion failed");

// A condition that, once seen, must be followed by another on the next edge.
`define SRP_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("slot pool assertion failed");

`else

`define SRP_ASSERT_ALWAYS(lbl, cond)
`define SRP_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== src/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool package
// Shared constants, the operation codes and the request token that travels
// down the chain of slot cells.
// ----------------------------------------------------------------------------
package srp_pkg;

   // Number of slots in the pool (1 to 64).
   localparam int SLOTS = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [7:0] REFS_MAX = 8'd255;

   // Minus one second in Q32.16 marks that no tick has been seen.
   localparam logic signed [47:0] LAST_TICK_NONE = -48'sd65536;

   localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      MODE_ACQUIRE = 2'd0,
      MODE_ADD_REF = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_TICK    = 2'd3
   } mode_type;

   // One request on its way through the cells, with its partial result.
   typedef struct packed {
      logic               valid;
      mode_type           mode;
      logic [31:0]        node;
      logic signed [31:0] dur;
      logic [7:0]         slot;
      logic signed [31:0] dt;
      logic               granted;
      logic [7:0]         sidx;
      logic [7:0]         cnt;
      logic [6:0]         expired;
   } token_type;

endpackage

// ===== src/srp_entry.sv =====
// ----------------------------------------------------------------------------
// Slot pool entry stage
// Keeps the time of the last tick, works out the elapsed time of a tick
// request and loads the request token at the head of the cell chain.
// ----------------------------------------------------------------------------
module srp_entry (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 req_valid,
   input  srp_pkg::mode_type    req_mode,
   input  logic [31:0]          req_node,
   input  logic signed [31:0]   req_dur,
   input  logic [7:0]           req_slot,
   input  logic signed [47:0]   req_now,
   output srp_pkg::token_type   tok_out
);
   import srp_pkg::*;

   logic signed [47:0] last_tick_ff;
   logic signed [47:0] last_tick_in;
   logic signed [48:0] diff;
   logic signed [31:0] dt;
   logic               valid_ff;
   token_type          tok_ff;
   token_type          tok_in;

   // Elapsed time since the last tick, saturated to Q16.16.
   always_comb begin
      diff = {req_now[47], req_now} - {last_tick_ff[47], last_tick_ff};
      if (last_tick_ff[47]) begin
         dt = '0;
      end else if (diff[48:31] == {18{diff[48]}}) begin
         dt = diff[31:0];
      end else if (diff[48]) begin
         dt = Q16_MIN;
      end else begin
         dt = Q16_MAX;
      end
   end

   // A tick request replaces the stored time.
   always_comb begin
      last_tick_in = last_tick_ff;
      if (advance && req_valid && (req_mode == MODE_TICK)) begin
         last_tick_in = req_now;
      end
   end

   // Build the token with an empty partial result.
   always_comb begin
      tok_in.valid   = req_valid;
      tok_in.mode    = req_mode;
      tok_in.node    = req_node;
      tok_in.dur     = req_dur;
      tok_in.slot    = req_slot;
      tok_in.dt      = dt;
      tok_in.granted = 1'b0;
      tok_in.sidx    = (req_mode == MODE_ACQUIRE) ? 8'd0 : req_slot;
      tok_in.cnt     = 8'd0;
      tok_in.expired = 7'd0;
   end

   // Control state: last tick time and token valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= LAST_TICK_NONE;
         valid_ff     <= 1'b0;
      end else begin
         last_tick_ff <= last_tick_in;
         if (advance) begin
            valid_ff <= tok_in.valid;
         end
      end
   end

   // Token payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff <= tok_in;
      end
   end

   // The valid bit comes from the reset-cleared register.
   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = valid_ff;
   end

endmodule

// ===== src/srp_cell.sv =====
// ----------------------------------------------------------------------------
// Slot pool cell
// Holds one slot (node id, remaining lifetime, reference count), applies the
// passing request to it and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module srp_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [srp_pkg::SLOT_W-1:0]  cell_idx,
   input  srp_pkg::token_type          tok_in,
   output srp_pkg::token_type          tok_out
);
   import srp_pkg::*;

   logic [31:0]        node_ff;
   logic [31:0]        node_in;
   logic signed [31:0] rem_ff;
   logic signed [31:0] rem_in;
   logic [7:0]         refs_ff;
   logic [7:0]         refs_in;
   logic               valid_ff;
   token_type          tok_ff;
   token_type          tok_nx;
   logic               live;
   logic               hit;
   logic signed [32:0] rem_diff;
   logic signed [31:0] rem_sat;

   // Lifetime after the elapsed time, saturated to Q16.16.
   always_comb begin
      rem_diff = {rem_ff[31], rem_ff} - {tok_in.dt[31], tok_in.dt};
      if (rem_diff[32] == rem_diff[31]) begin
         rem_sat = rem_diff[31:0];
      end else if (rem_diff[32]) begin
         rem_sat = Q16_MIN;
      end else begin
         rem_sat = Q16_MAX;
      end
   end

   // Apply the request to this slot.
   always_comb begin
      tok_nx  = tok_in;
      node_in = node_ff;
      rem_in  = rem_ff;
      refs_in = refs_ff;
      live    = (refs_ff != 8'd0);
      hit     = (tok_in.slot == 8'(cell_idx));
      case (tok_in.mode)
         MODE_ACQUIRE: begin
            if (!tok_in.granted && !live) begin
               node_in        = tok_in.node;
               rem_in         = tok_in.dur;
               refs_in        = 8'd1;
               tok_nx.granted = 1'b1;
               tok_nx.sidx    = 8'(cell_idx);
               tok_nx.cnt     = 8'd1;
            end
         end
         MODE_ADD_REF: begin
            if (hit && live) begin
               if (refs_ff != REFS_MAX) begin
                  refs_in = refs_ff + 8'd1;
               end
               tok_nx.cnt = refs_in;
            end
         end
         MODE_RELEASE: begin
            if (hit && live) begin
               refs_in = refs_ff - 8'd1;
               if (refs_in == 8'd0) begin
                  rem_in  = '0;
                  node_in = '0;
               end
               tok_nx.cnt = refs_in;
            end
         end
         MODE_TICK: begin
            if (live) begin
               rem_in = rem_sat;
               if (rem_sat <= 32'sd0) begin
                  refs_in = refs_ff - 8'd1;
                  if (refs_in == 8'd0) begin
                     rem_in  = '0;
                     node_in = '0;
                  end
                  tok_nx.expired = tok_in.expired + 7'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state: reference count and token valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         refs_ff  <= 8'd0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tok_nx.valid;
         if (tok_in.valid) begin
            refs_ff <= refs_in;
         end
      end
   end

   // Slot payload and the token handed to the next cell.
   always_ff @(posedge clock) begin
      if (advance) begin
         tok_ff <= tok_nx;
         if (tok_in.valid) begin
            node_ff <= node_in;
            rem_ff  <= rem_in;
         end
      end
   end

   // The valid bit comes from the reset-cleared register.
   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = valid_ff;
   end

endmodule

// ===== src/refcounted_timed_slot_pool_unit.sv =====
// ----------------------------------------------------------------------------
// Reference-counted timed slot pool
// The entry stage and one cell per slot are registered between request accept and rsp_tvalid.
// Throughput: one request per cycle; each request walks the chain of slot
// cells, one cell per cycle, and later requests follow right behind it.
// The whole chain stalls while a result waits on rsp_tready.
// Reset: all slots free and no tick seen, with no clearing pass.
// ----------------------------------------------------------------------------
`include "refcounted_timed_slot_pool_unit_macros.svh"

module refcounted_timed_slot_pool_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // node_id[31:0], duration[63:32], slot[71:64], now_time[119:72]
   input  logic [119:0]  req_tdata,
   // mode[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // granted[0], slot_index[8:1], count_after[16:9], expired_count[23:17]
   output logic [23:0]   rsp_tdata
);
   import srp_pkg::*;

   token_type stage_tok [0:SLOTS];
   token_type rsp_tok;
   logic      advance;
   logic      grant_ok;
   logic      expired_ok;

   // The chain moves whenever the last stage is empty or being taken.
   assign advance    = !stage_tok[SLOTS].valid || rsp_tready;
   assign req_tready = advance;

   srp_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_tvalid),
      .req_mode  (mode_type'(req_tuser)),
      .req_node  (req_tdata[31:0]),
      .req_dur   (req_tdata[63:32]),
      .req_slot  (req_tdata[71:64]),
      .req_now   (req_tdata[119:72]),
      .tok_out   (stage_tok[0])
   );

   // One cell for each slot; cell i hands its token to cell i + 1.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      srp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (SLOT_W'(i)),
         .tok_in   (stage_tok[i]),
         .tok_out  (stage_tok[i + 1])
      );
   end

   // The last stage is the result register.
   assign rsp_tok    = stage_tok[SLOTS];
   assign rsp_tvalid = rsp_tok.valid;
   assign rsp_tdata  = {rsp_tok.expired, rsp_tok.cnt, rsp_tok.sidx, rsp_tok.granted};

   // Result properties checked below.
   assign grant_ok   = !rsp_tok.granted || (rsp_tok.mode == MODE_ACQUIRE);
   assign expired_ok = (rsp_tok.expired == 7'd0) ||
                       ((rsp_tok.mode == MODE_TICK) && (rsp_tok.expired <= 7'(SLOTS)));

   // A grant only comes from an acquire.
   `SRP_ASSERT_ALWAYS(a_grant_acquire, !rsp_tvalid || grant_ok)

   // Only a tick counts expirations, and never more than the pool holds.
   `SRP_ASSERT_ALWAYS(a_expired_tick, !rsp_tvalid || expired_ok)

   // An accepted request enters the head of the chain.
   `SRP_ASSERT_NEXT(a_enter_chain, req_tvalid && req_tready, stage_tok[0].valid)

endmodule
